// ----- rtl/tdkm_pkg.sv -----
package tdkm_pkg;

	localparam int COUNTER_WIDTH = 8;
	localparam int PADDR_W       = 4;
	localparam int PDATA_W       = 32;

	localparam logic [7:0] PHASE_TICKS_RST = 8'd10;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
	localparam logic [7:0] KEY_CMD_RST     = 8'h49;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_PHASE_TICKS = 2'd0;
	localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_KEY_CMD     = 2'd2;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_START_A, S_START_B, S_START_C, S_TX_LOW, S_TX_HIGH,
		S_ACK_LOW, S_ACK_HIGH, S_ACK_DONE, S_RX_LOW, S_RX_HIGH,
		S_NACK_LOW, S_NACK_HIGH, S_STOP_A, S_STOP_B, S_STOP_C
	} step_t;

	typedef struct packed {
		logic [7:0] phase_ticks;
		logic [7:0] ack_timeout;
		logic [7:0] key_read_command;
	} cfg_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] addr_byte;
		logic [7:0] data_byte;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic       ack_missing;
		logic [7:0] key_code;
	} res_t;

endpackage

// ----- rtl/tdkm_in_if.sv -----
interface tdkm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] addr_byte;
	logic [7:0] data_byte;
	logic       sda_in;

	modport source (output valid, action, addr_byte, data_byte, sda_in, input ready);
	modport sink (input valid, action, addr_byte, data_byte, sda_in, output ready);
endinterface

// ----- rtl/tdkm_out_if.sv -----
interface tdkm_out_if;
	logic       valid;
	logic       ready;
	logic       scl;
	logic       sda_out;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic       ack_missing;
	logic [7:0] key_code;

	modport source (output valid, scl, sda_out, sda_drive, busy_res, done_res, ack_missing,
		key_code, input ready);
	modport sink (input valid, scl, sda_out, sda_drive, busy_res, done_res, ack_missing,
		key_code, output ready);
endinterface

// ----- rtl/two_wire_display_key_master.sv -----
// Two-wire bus master for a display and key controller. Every accepted input
// item is one timebase tick: it may start a write (address byte, data byte) or
// a key read while idle, carries the sampled data line, and yields exactly one
// result with the clock and data line levels for that tick plus busy, done,
// ack_missing and the last key code. One item is accepted per clock cycle while
// input ready is high; its result is registered in the output or skid register.
// The sequencer state advances in a single pass of logic per tick. Input ready
// drops only when both the output register and the skid register hold unread
// results. Bus timing is set by phase_ticks ticks per clock phase and
// ack_timeout high ticks per acknowledge wait, both written over the APB port
// at byte addresses 0 and 4; the key read command byte lies at address 8.
module two_wire_display_key_master #(
	parameter int COUNTER_WIDTH = tdkm_pkg::COUNTER_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tdkm_in_if.sink                       in_ch,
	tdkm_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tdkm_pkg::PADDR_W-1:0]  paddr,
	input  logic [tdkm_pkg::PDATA_W-1:0]  pwdata,
	output logic [tdkm_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	tdkm_pkg::cfg_t  cfg;
	tdkm_pkg::item_t item;
	tdkm_pkg::res_t  res, out_res;
	logic            in_ready, acc;

	assign item.action    = in_ch.action;
	assign item.addr_byte = in_ch.addr_byte;
	assign item.data_byte = in_ch.data_byte;
	assign item.sda_in    = in_ch.sda_in;
	assign in_ch.ready    = in_ready;
	assign acc            = in_ch.valid & in_ready;

	tdkm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tdkm_seq #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.item   (item),
		.cfg    (cfg),
		.res    (res)
	);

	tdkm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.in_res    (res),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_res   (out_res)
	);

	assign out_ch.scl         = out_res.scl;
	assign out_ch.sda_out     = out_res.sda_out;
	assign out_ch.sda_drive   = out_res.sda_drive;
	assign out_ch.busy_res    = out_res.busy_res;
	assign out_ch.done_res    = out_res.done_res;
	assign out_ch.ack_missing = out_res.ack_missing;
	assign out_ch.key_code    = out_res.key_code;

endmodule

// ----- rtl/tdkm_cfg.sv -----
module tdkm_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tdkm_pkg::PADDR_W-1:0]  paddr,
	input  logic [tdkm_pkg::PDATA_W-1:0]  pwdata,
	output logic [tdkm_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output tdkm_pkg::cfg_t                cfg
);

	tdkm_pkg::cfg_t cfg_q;
	logic           wr;
	logic [1:0]     idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_ticks      <= tdkm_pkg::PHASE_TICKS_RST;
			cfg_q.ack_timeout      <= tdkm_pkg::ACK_TIMEOUT_RST;
			cfg_q.key_read_command <= tdkm_pkg::KEY_CMD_RST;
		end else if (wr) begin
			case (idx)
				tdkm_pkg::REG_PHASE_TICKS: cfg_q.phase_ticks      <= pwdata[7:0];
				tdkm_pkg::REG_ACK_TIMEOUT: cfg_q.ack_timeout      <= pwdata[7:0];
				tdkm_pkg::REG_KEY_CMD:     cfg_q.key_read_command <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tdkm_pkg::REG_PHASE_TICKS: prdata = {24'd0, cfg_q.phase_ticks};
			tdkm_pkg::REG_ACK_TIMEOUT: prdata = {24'd0, cfg_q.ack_timeout};
			tdkm_pkg::REG_KEY_CMD:     prdata = {24'd0, cfg_q.key_read_command};
			default:                   prdata = '0;
		endcase
	end

endmodule

// ----- rtl/tdkm_seq.sv -----
module tdkm_seq #(
	parameter int COUNTER_WIDTH = tdkm_pkg::COUNTER_WIDTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            acc,
	input  tdkm_pkg::item_t item,
	input  tdkm_pkg::cfg_t  cfg,
	output tdkm_pkg::res_t  res
);

	localparam int CMPW = (COUNTER_WIDTH > 8) ? COUNTER_WIDTH : 8;
	localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

	tdkm_pkg::step_t          st_q, st_c, st_n;
	logic [COUNTER_WIDTH-1:0] pc_q, pc_c, pc_n;
	logic [COUNTER_WIDTH-1:0] wc_q, wc_c, wc_n, wc_inc;
	logic [2:0]               bc_q, bc_c, bc_n;
	logic [7:0]               sb_q, sb_c, sb_n, sb_rx;
	logic [7:0]               hd_q, hd_c;
	logic                     bi_q, bi_c, bi_n;
	logic                     ir_q, ir_c;
	logic [7:0]               ks_q, ks_n;
	logic                     af_q, af_c, af_n;
	logic [7:0]               eff_phase, eff_to;
	logic                     pe;
	logic                     scl, sda, drive, done;

	assign eff_phase = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
	assign eff_to    = (cfg.ack_timeout == 8'd0) ? 8'd1 : cfg.ack_timeout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tdkm_pkg::S_IDLE;
			pc_q <= '0;
			wc_q <= '0;
			bc_q <= '0;
			sb_q <= '0;
			hd_q <= '0;
			bi_q <= 1'b0;
			ir_q <= 1'b0;
			ks_q <= '0;
			af_q <= 1'b0;
		end else if (acc) begin
			st_q <= st_n;
			pc_q <= pc_n;
			wc_q <= wc_n;
			bc_q <= bc_n;
			sb_q <= sb_n;
			hd_q <= hd_c;
			bi_q <= bi_n;
			ir_q <= ir_c;
			ks_q <= ks_n;
			af_q <= af_n;
		end
	end

	always_comb begin
		// command start only from idle
		st_c = st_q; pc_c = pc_q; wc_c = wc_q; bc_c = bc_q; sb_c = sb_q;
		hd_c = hd_q; bi_c = bi_q; ir_c = ir_q; af_c = af_q;
		if (st_q == tdkm_pkg::S_IDLE &&
		    (item.action == tdkm_pkg::ACT_WRITE || item.action == tdkm_pkg::ACT_READ)) begin
			ir_c = (item.action == tdkm_pkg::ACT_READ);
			af_c = 1'b0;
			sb_c = ir_c ? cfg.key_read_command : item.addr_byte;
			hd_c = item.data_byte;
			bi_c = 1'b0;
			bc_c = '0;
			wc_c = '0;
			st_c = tdkm_pkg::S_START_A;
			pc_c = '0;
		end

		scl = 1'b1; sda = 1'b1; drive = 1'b1;
		case (st_c)
			tdkm_pkg::S_START_A:   begin scl = 1'b1; sda = 1'b1; end
			tdkm_pkg::S_START_B:   begin scl = 1'b1; sda = 1'b0; end
			tdkm_pkg::S_START_C:   begin scl = 1'b0; sda = 1'b0; end
			tdkm_pkg::S_TX_LOW:    begin scl = 1'b0; sda = sb_c[7]; end
			tdkm_pkg::S_TX_HIGH:   begin scl = 1'b1; sda = sb_c[7]; end
			tdkm_pkg::S_ACK_LOW:   begin scl = 1'b0; drive = 1'b0; end
			tdkm_pkg::S_ACK_HIGH:  begin scl = 1'b1; drive = 1'b0; end
			tdkm_pkg::S_ACK_DONE:  begin scl = 1'b0; drive = 1'b0; end
			tdkm_pkg::S_RX_LOW:    begin scl = 1'b0; drive = 1'b0; end
			tdkm_pkg::S_RX_HIGH:   begin scl = 1'b1; drive = 1'b0; end
			tdkm_pkg::S_NACK_LOW:  begin scl = 1'b0; sda = 1'b1; end
			tdkm_pkg::S_NACK_HIGH: begin scl = 1'b1; sda = 1'b1; end
			tdkm_pkg::S_STOP_A:    begin scl = 1'b0; sda = 1'b0; end
			tdkm_pkg::S_STOP_B:    begin scl = 1'b1; sda = 1'b0; end
			tdkm_pkg::S_STOP_C:    begin scl = 1'b1; sda = 1'b1; end
			default: ;
		endcase
		// released line reads as the pull-up level
		if (!drive) sda = 1'b1;

		pe = (CMPW'(pc_c) >= CMPW'(eff_phase - 8'd1)) || (pc_c == CNT_MAX);
		wc_inc = (wc_c != CNT_MAX) ? wc_c + 1'b1 : wc_c;
		sb_rx = {sb_c[6:0], item.sda_in};

		st_n = st_c; wc_n = wc_c; bc_n = bc_c; sb_n = sb_c; bi_n = bi_c;
		ks_n = ks_q; af_n = af_c; done = 1'b0;
		pc_n = pe ? '0 : pc_c + 1'b1;

		case (st_c)
			tdkm_pkg::S_IDLE: pc_n = pc_c;
			tdkm_pkg::S_START_A: if (pe) st_n = tdkm_pkg::S_START_B;
			tdkm_pkg::S_START_B: if (pe) st_n = tdkm_pkg::S_START_C;
			tdkm_pkg::S_START_C: if (pe) st_n = tdkm_pkg::S_TX_LOW;
			tdkm_pkg::S_TX_LOW:  if (pe) st_n = tdkm_pkg::S_TX_HIGH;
			tdkm_pkg::S_TX_HIGH: begin
				if (pe) begin
					sb_n = {sb_c[6:0], 1'b0};
					bc_n = bc_c + 3'd1;
					st_n = (bc_c == 3'd7) ? tdkm_pkg::S_ACK_LOW : tdkm_pkg::S_TX_LOW;
				end
			end
			tdkm_pkg::S_ACK_LOW: begin
				if (pe) begin
					wc_n = '0;
					st_n = tdkm_pkg::S_ACK_HIGH;
				end
			end
			tdkm_pkg::S_ACK_HIGH: begin
				// phase counter is not run while waiting for the acknowledge
				pc_n = pc_c;
				if (!item.sda_in) begin
					st_n = tdkm_pkg::S_ACK_DONE;
					pc_n = '0;
				end else begin
					wc_n = wc_inc;
					if (CMPW'(wc_inc) >= CMPW'(eff_to) || wc_inc == CNT_MAX) begin
						af_n = 1'b1;
						st_n = tdkm_pkg::S_STOP_A;
						pc_n = '0;
					end
				end
			end
			tdkm_pkg::S_ACK_DONE: begin
				if (pe) begin
					if (ir_c) begin
						bc_n = '0;
						sb_n = '0;
						st_n = tdkm_pkg::S_RX_LOW;
					end else if (!bi_c) begin
						bi_n = 1'b1;
						bc_n = '0;
						sb_n = hd_c;
						st_n = tdkm_pkg::S_TX_LOW;
					end else begin
						st_n = tdkm_pkg::S_STOP_A;
					end
				end
			end
			tdkm_pkg::S_RX_LOW: if (pe) st_n = tdkm_pkg::S_RX_HIGH;
			tdkm_pkg::S_RX_HIGH: begin
				// sample on the first tick of the high phase
				if (pc_c == '0) sb_n = sb_rx;
				if (pe) begin
					bc_n = bc_c + 3'd1;
					if (bc_c == 3'd7) begin
						ks_n = sb_n;
						st_n = tdkm_pkg::S_NACK_LOW;
					end else begin
						st_n = tdkm_pkg::S_RX_LOW;
					end
				end
			end
			tdkm_pkg::S_NACK_LOW:  if (pe) st_n = tdkm_pkg::S_NACK_HIGH;
			tdkm_pkg::S_NACK_HIGH: if (pe) st_n = tdkm_pkg::S_STOP_A;
			tdkm_pkg::S_STOP_A:    if (pe) st_n = tdkm_pkg::S_STOP_B;
			tdkm_pkg::S_STOP_B:    if (pe) st_n = tdkm_pkg::S_STOP_C;
			tdkm_pkg::S_STOP_C: begin
				if (pe) begin
					done = 1'b1;
					st_n = tdkm_pkg::S_IDLE;
				end
			end
			default: begin
				st_n = tdkm_pkg::S_IDLE;
				pc_n = '0;
			end
		endcase

		res.scl         = scl;
		res.sda_out     = sda;
		res.sda_drive   = drive;
		res.busy_res    = (st_c != tdkm_pkg::S_IDLE);
		res.done_res    = done;
		res.ack_missing = af_n;
		res.key_code    = ks_n;
	end

endmodule

// ----- rtl/tdkm_skid.sv -----
module tdkm_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tdkm_pkg::res_t in_res,
	output logic           out_valid,
	input  logic           out_ready,
	output tdkm_pkg::res_t out_res
);

	logic           out_v_q, skid_v_q;
	tdkm_pkg::res_t out_q, skid_q;
	logic           acc, take;

	assign in_ready  = !skid_v_q;
	assign acc       = in_valid & in_ready;
	assign take      = out_v_q & out_ready;
	assign out_valid = out_v_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || take) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= acc;
			end else begin
				out_v_q  <= acc;
			end
		end else if (acc) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || take) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (acc) skid_q <= in_res;
			end else if (acc) begin
				out_q <= in_res;
			end
		end else if (acc) begin
			skid_q <= in_res;
		end
	end

endmodule

// ----- bench/tdkm_checker.sv -----
module tdkm_checker
	import tdkm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	tdkm_in_if                 in_ch,
	tdkm_out_if                out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 ticks_owed,
	output logic               bus_idle
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = COUNTER_WIDTH;
	localparam logic [CW-1:0] CNT_MAX = '1;

	cfg_t          cfg;
	step_t         seq_step;
	logic [CW-1:0] phase_cnt;
	logic [CW-1:0] wait_cnt;
	logic [3:0]    bit_cnt;
	logic [7:0]    shifter;
	logic [7:0]    held_byte;
	logic [7:0]    key_byte;
	logic [1:0]    byte_idx;
	logic          reading;
	logic          ack_lost;

	res_t tick_results[$];

	function automatic logic [7:0] at_least_one(logic [7:0] v);
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

	// true on the last tick of a bus phase; the counter then restarts from zero
	function automatic logic phase_done();
		if (phase_cnt >= at_least_one(cfg.phase_ticks) - 1 || phase_cnt == CNT_MAX) begin
			phase_cnt = '0;
			return 1'b1;
		end
		phase_cnt++;
		return 1'b0;
	endfunction

	function automatic void enter(step_t s);
		seq_step = s;
		phase_cnt = '0;
	endfunction

	// line levels and flags for one tick, then advance the sequencer
	function automatic res_t advance_bus(item_t it);
		res_t r;
		logic scl_v, sda_v, drv_v, done_v;
		scl_v = 1'b1;
		sda_v = 1'b1;
		drv_v = 1'b1;
		done_v = 1'b0;

		if (seq_step == S_IDLE && (it.action == ACT_WRITE || it.action == ACT_READ)) begin
			reading = (it.action == ACT_READ);
			ack_lost = 1'b0;
			shifter = reading ? cfg.key_read_command : it.addr_byte;
			held_byte = it.data_byte;
			byte_idx = '0;
			bit_cnt = '0;
			wait_cnt = '0;
			enter(S_START_A);
		end

		case (seq_step)
			S_START_B: sda_v = 1'b0;
			S_START_C: begin
				scl_v = 1'b0;
				sda_v = 1'b0;
			end
			S_TX_LOW: begin
				scl_v = 1'b0;
				sda_v = shifter[7];
			end
			S_TX_HIGH: sda_v = shifter[7];
			S_ACK_LOW, S_ACK_DONE, S_RX_LOW: begin
				scl_v = 1'b0;
				drv_v = 1'b0;
			end
			S_ACK_HIGH, S_RX_HIGH: drv_v = 1'b0;
			S_NACK_LOW: scl_v = 1'b0;
			S_STOP_A: begin
				scl_v = 1'b0;
				sda_v = 1'b0;
			end
			S_STOP_B: sda_v = 1'b0;
			default: ;
		endcase
		// released line reads as the pull-up level
		if (!drv_v) sda_v = 1'b1;
		r.busy_res = (seq_step != S_IDLE);

		case (seq_step)
			S_START_A: if (phase_done()) enter(S_START_B);
			S_START_B: if (phase_done()) enter(S_START_C);
			S_START_C: if (phase_done()) enter(S_TX_LOW);
			S_TX_LOW:  if (phase_done()) enter(S_TX_HIGH);
			S_TX_HIGH: if (phase_done()) begin
				shifter = {shifter[6:0], 1'b0};
				bit_cnt++;
				if (bit_cnt >= 4'd8) begin
					bit_cnt = '0;
					enter(S_ACK_LOW);
				end else begin
					enter(S_TX_LOW);
				end
			end
			S_ACK_LOW: if (phase_done()) begin
				wait_cnt = '0;
				enter(S_ACK_HIGH);
			end
			S_ACK_HIGH: begin
				if (!it.sda_in) begin
					enter(S_ACK_DONE);
				end else begin
					if (wait_cnt != CNT_MAX) wait_cnt++;
					if (wait_cnt >= at_least_one(cfg.ack_timeout) || wait_cnt == CNT_MAX) begin
						ack_lost = 1'b1;
						enter(S_STOP_A);
					end
				end
			end
			S_ACK_DONE: if (phase_done()) begin
				if (reading) begin
					bit_cnt = '0;
					shifter = '0;
					enter(S_RX_LOW);
				end else if (byte_idx == 2'd0) begin
					byte_idx = 2'd1;
					bit_cnt = '0;
					shifter = held_byte;
					enter(S_TX_LOW);
				end else begin
					enter(S_STOP_A);
				end
			end
			S_RX_LOW: if (phase_done()) enter(S_RX_HIGH);
			S_RX_HIGH: begin
				// sample on the first tick of the high phase
				if (phase_cnt == '0) shifter = {shifter[6:0], it.sda_in};
				if (phase_done()) begin
					bit_cnt++;
					if (bit_cnt >= 4'd8) begin
						bit_cnt = '0;
						key_byte = shifter;
						enter(S_NACK_LOW);
					end else begin
						enter(S_RX_LOW);
					end
				end
			end
			S_NACK_LOW:  if (phase_done()) enter(S_NACK_HIGH);
			S_NACK_HIGH: if (phase_done()) enter(S_STOP_A);
			S_STOP_A:    if (phase_done()) enter(S_STOP_B);
			S_STOP_B:    if (phase_done()) enter(S_STOP_C);
			S_STOP_C: if (phase_done()) begin
				done_v = 1'b1;
				enter(S_IDLE);
			end
			default: ;
		endcase

		r.scl = scl_v;
		r.sda_out = sda_v;
		r.sda_drive = drv_v;
		r.done_res = done_v;
		r.ack_missing = ack_lost;
		r.key_code = key_byte;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t got;
		res_t want;
		item_t it;
		if (!arst_n) begin
			cfg = '{PHASE_TICKS_RST, ACK_TIMEOUT_RST, KEY_CMD_RST};
			seq_step = S_IDLE;
			phase_cnt = '0;
			wait_cnt = '0;
			bit_cnt = '0;
			shifter = '0;
			held_byte = '0;
			key_byte = '0;
			byte_idx = '0;
			reading = 1'b0;
			ack_lost = 1'b0;
			tick_results.delete();
			mismatches = 0;
			ticks_owed = 0;
			bus_idle = 1'b1;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_PHASE_TICKS: cfg.phase_ticks = pwdata[7:0];
					REG_ACK_TIMEOUT: cfg.ack_timeout = pwdata[7:0];
					REG_KEY_CMD:     cfg.key_read_command = pwdata[7:0];
					default: ;
				endcase
			end

			// results leave in tick order, so compare before queuing this edge's tick
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.scl, out_ch.sda_out, out_ch.sda_drive, out_ch.busy_res,
					out_ch.done_res, out_ch.ack_missing, out_ch.key_code};
				if (tick_results.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result transaction %p", $time, got);
					mismatches++;
				end else begin
					want = tick_results.pop_front();
					if (got.scl !== want.scl || got.sda_out !== want.sda_out
							|| got.sda_drive !== want.sda_drive
							|| got.busy_res !== want.busy_res
							|| got.done_res !== want.done_res
							|| got.ack_missing !== want.ack_missing
							|| got.key_code !== want.key_code) begin
						if (mismatches < 10) begin
							$display("%0t: mismatch scl/sda/drive/busy/done/ack_missing/key",
								$time);
							$display("  expected %b %b %b %b %b %b %02h", want.scl,
								want.sda_out, want.sda_drive, want.busy_res, want.done_res,
								want.ack_missing, want.key_code);
							$display("  actual   %b %b %b %b %b %b %02h", got.scl,
								got.sda_out, got.sda_drive, got.busy_res, got.done_res,
								got.ack_missing, got.key_code);
						end
						mismatches++;
					end
				end
			end

			if (in_ch.valid && in_ch.ready) begin
				it = '{in_ch.action, in_ch.addr_byte, in_ch.data_byte, in_ch.sda_in};
				tick_results.push_back(advance_bus(it));
			end

			ticks_owed = tick_results.size();
			bus_idle = (seq_step == S_IDLE);
		end
	end

endmodule

// ----- bench/tb_two_wire_display_key_master.sv -----
module tb_two_wire_display_key_master;
	timeunit 1ns;
	timeprecision 1ps;
	import tdkm_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef enum int {SDA_RANDOM, SDA_MOSTLY_LOW, SDA_MOSTLY_HIGH, SDA_NEVER} sda_mode_e;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int   mismatches;
	int   ticks_owed;
	logic bus_idle;
	int   ticks_sent;
	logic no_gaps;

	// bus settings per run phase: short, zero (read as one), mid with longest timeout,
	// shortest timeout, odd
	cfg_t plan [5] = '{
		'{8'd1,   8'd4,   8'h00},
		'{8'd0,   8'd0,   8'hFF},
		'{8'd3,   8'd255, 8'h5A},
		'{8'd8,   8'd1,   8'hA5},
		'{8'd2,   8'd7,   8'h81}
	};
	int plan_ticks [5] = '{60, 60, 60, 1, 60};

	tdkm_in_if  in_ch();
	tdkm_out_if out_ch();

	two_wire_display_key_master uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tdkm_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (mismatches),
		.ticks_owed (ticks_owed),
		.bus_idle   (bus_idle)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mostly short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic sda_level(sda_mode_e mode);
		case (mode)
			SDA_MOSTLY_LOW:  return $urandom_range(0, 7) == 0;
			SDA_MOSTLY_HIGH: return $urandom_range(0, 15) != 0;
			SDA_NEVER:       return 1'b1;
			default:         return 1'($urandom_range(0, 1));
		endcase
	endfunction

	// entered and left at a falling edge; valid stays up after the transaction
	task automatic send_item(input item_t it);
		int gap;
		gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= it.action;
		in_ch.addr_byte <= it.addr_byte;
		in_ch.data_byte <= it.data_byte;
		in_ch.sda_in <= it.sda_in;
		do @(posedge clk); while (!in_ch.ready);
		ticks_sent++;
		@(negedge clk);
	endtask

	// commands arriving mid-transaction must be ignored, so ticks carry some
	task automatic run_command(input logic [1:0] act, input logic [7:0] a,
			input logic [7:0] d, input sda_mode_e mode);
		no_gaps = ($urandom_range(0, 3) == 0);
		send_item('{act, a, d, 1'($urandom_range(0, 1))});
		while (!bus_idle)
			send_item('{($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : ACT_TICK,
				8'($urandom), 8'($urandom), sda_level(mode)});
	endtask

	task automatic settle();
		while (!bus_idle)
			send_item('{ACT_TICK, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1))});
		in_ch.valid <= 1'b0;
		while (ticks_owed != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= PDATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int start;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_TICK;
		in_ch.addr_byte = '0;
		in_ch.data_byte = '0;
		in_ch.sda_in = 1'b1;
		ticks_sent = 0;
		no_gaps = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, including the default key read command
		run_command(ACT_READ, 8'($urandom), 8'($urandom), SDA_RANDOM);
		settle();

		for (int p = 0; p < 5; p++) begin
			reg_write(REG_PHASE_TICKS, plan[p].phase_ticks);
			reg_write(REG_ACK_TIMEOUT, plan[p].ack_timeout);
			reg_write(REG_KEY_CMD, plan[p].key_read_command);

			if (p == 0) begin
				send_item('{ACT_UNUSED, 8'hFF, 8'hFF, 1'b0});
				send_item('{ACT_TICK, 8'h00, 8'h00, 1'b1});
				run_command(ACT_WRITE, 8'h00, 8'hFF, SDA_MOSTLY_LOW);
				run_command(ACT_WRITE, 8'hFF, 8'h00, SDA_MOSTLY_LOW);
				run_command(ACT_READ, 8'h00, 8'h00, SDA_RANDOM);
				// abort during a read leaves the key code alone
				run_command(ACT_READ, 8'hFF, 8'hFF, SDA_NEVER);
				run_command(ACT_WRITE, 8'hA5, 8'h5A, SDA_NEVER);
				// next accepted command clears ack_missing
				run_command(ACT_WRITE, 8'h5A, 8'hA5, SDA_MOSTLY_LOW);
				run_command(ACT_READ, 8'h3C, 8'hC3, SDA_MOSTLY_HIGH);
			end

			start = ticks_sent;
			while (ticks_sent - start < plan_ticks[p]) begin
				if ($urandom_range(0, 4) == 0) begin
					no_gaps = ($urandom_range(0, 3) == 0);
					repeat ($urandom_range(1, 20))
						send_item('{2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
							1'($urandom_range(0, 1))});
				end else begin
					run_command(($urandom_range(0, 1) != 0) ? ACT_READ : ACT_WRITE,
						8'($urandom), 8'($urandom), sda_mode_e'($urandom_range(0, 3)));
				end
			end
			settle();
		end

		repeat (8) @(negedge clk);
		if (mismatches == 0 && ticks_owed == 0) begin
			$display("[two_wire_display_key_master] OK");
		end else begin
			$display("[two_wire_display_key_master] ERROR");
		end
		$finish;
	end

	// result side: ready in random runs, stalls mostly short
	initial begin
		int hold;
		logic go_high;
		hold = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				go_high = ($urandom_range(0, 2) != 0);
				hold = go_high ? $urandom_range(1, 40) : pick_gap();
				out_ch.ready <= go_high;
			end
			hold--;
		end
	end

	initial begin
		#10_000_000;
		$display("[two_wire_display_key_master] ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/tdkm_pkg.sv
rtl/tdkm_in_if.sv
rtl/tdkm_out_if.sv
rtl/tdkm_cfg.sv
rtl/tdkm_seq.sv
rtl/tdkm_skid.sv
rtl/two_wire_display_key_master.sv
bench/tdkm_checker.sv
bench/tb_two_wire_display_key_master.sv
